// ----- hdl/nrmc_pkg.sv -----
// Shared types, character codes and constant tables for the RMC position parser.
// Used by nrmc_deg_conv and nmea_rmc_position_parser_core; no dependencies.
`default_nettype none

package nrmc_pkg;

	localparam int LINE_MAX_DEF    = 128;
	localparam int FRAC_DIGITS_DEF = 4;

	localparam int ACC_W      = 28;
	localparam int FRAC_CNT_W = 3;
	localparam int LAT_W      = 31;
	localparam int LON_W      = 32;
	localparam int PREFIX_LEN = 6;

	localparam logic [ACC_W-1:0] ACC_MAX   = '1;
	localparam logic [31:0]      LAT_LIMIT = 32'd900000000;
	localparam logic [31:0]      LON_LIMIT = 32'd1800000000;

	// character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0a;
	localparam logic [7:0] CH_VT    = 8'h0b;
	localparam logic [7:0] CH_FF    = 8'h0c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_DOT   = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_W     = 8'h57;

	// token indexes (counted from zero)
	localparam logic [4:0] FLD_STATUS = 5'd2;
	localparam logic [4:0] FLD_LAT    = 5'd3;
	localparam logic [4:0] FLD_NS     = 5'd4;
	localparam logic [4:0] FLD_LON    = 5'd5;
	localparam logic [4:0] FLD_EW     = 5'd6;
	localparam logic [4:0] MIN_FIELDS = 5'd7;
	localparam logic [4:0] FIELD_SAT  = 5'd31;

	// status token
	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_A     = 2'd1;
	localparam logic [1:0] ST_OTHER = 2'd2;

	// number reader states
	localparam logic [1:0] NUM_LEAD = 2'd0;
	localparam logic [1:0] NUM_INT  = 2'd1;
	localparam logic [1:0] NUM_FRAC = 2'd2;
	localparam logic [1:0] NUM_STOP = 2'd3;

	typedef struct packed {
		logic [4:0]            field_no;
		logic                  in_token;
		logic                  prefix_ok;
		logic [1:0]            status;
		logic [ACC_W-1:0]      lat_acc;
		logic [ACC_W-1:0]      lon_acc;
		logic [1:0]            num_stage;
		logic [FRAC_CNT_W-1:0] frac_cnt;
		logic                  lat_neg;
		logic                  lon_neg;
		logic                  south;
		logic                  west;
		logic                  text_end;
	} line_state_t;

	localparam line_state_t LINE_CLEAR = '{
		field_no:  '0,
		in_token:  1'b0,
		prefix_ok: 1'b1,
		status:    ST_NONE,
		lat_acc:   '0,
		lon_acc:   '0,
		num_stage: NUM_LEAD,
		frac_cnt:  '0,
		lat_neg:   1'b0,
		lon_neg:   1'b0,
		south:     1'b0,
		west:      1'b0,
		text_end:  1'b0
	};

	// one coordinate handed to the converter at line end
	typedef struct packed {
		logic [ACC_W-1:0] acc;
		logic             neg;
		logic             keep;
	} conv_req_t;

	function automatic logic [63:0] pow10(input logic [3:0] n);
		logic [63:0] v;
		unique case (n)
			4'd0:    v = 64'd1;
			4'd1:    v = 64'd10;
			4'd2:    v = 64'd100;
			4'd3:    v = 64'd1000;
			4'd4:    v = 64'd10000;
			4'd5:    v = 64'd100000;
			4'd6:    v = 64'd1000000;
			4'd7:    v = 64'd10000000;
			4'd8:    v = 64'd100000000;
			4'd9:    v = 64'd1000000000;
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0:    c = 8'h24; // $
			3'd1:    c = 8'h47; // G
			3'd2:    c = 8'h50; // P
			3'd3:    c = 8'h52; // R
			3'd4:    c = 8'h4d; // M
			3'd5:    c = 8'h43; // C
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ----- hdl/nrmc_deg_conv.sv -----
// Pipelined ddmm.mmmm to 1e-7 degree converter for one coordinate.
// Depends on nrmc_pkg. Eight stages, each stage stalls only when full.
`default_nettype none

module nrmc_deg_conv #(
	parameter int          FRACTION_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF,
	parameter logic [31:0] LIMIT           = nrmc_pkg::LAT_LIMIT,
	parameter int          OUT_W           = nrmc_pkg::LAT_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  nrmc_pkg::conv_req_t req,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_W-1:0]    value,
	output logic                keep
);
	import nrmc_pkg::*;

	localparam int          NSTAGE      = 8;
	localparam int          RECIP_SHIFT = 40;
	localparam int          QUO_W       = 20;
	localparam int          PROD_W      = 60;
	localparam int          DEG_W       = 44;
	localparam int          MINX_W      = 30;
	localparam logic [63:0] UNIT        = 64'd100 * pow10(4'(FRACTION_DIGITS));
	localparam logic [63:0] RECIP       = (64'd1 << RECIP_SHIFT) / UNIT;
	localparam logic [63:0] SCALE       = pow10(4'(7 - FRACTION_DIGITS));
	localparam logic [63:0] TEN7        = pow10(4'd7);
	// ceil(2^32/15): exact quotient for dividends below 2^28
	localparam logic [63:0] RECIP15     = 64'd286331154;

	logic [NSTAGE:1]   vld_s;
	logic [NSTAGE+1:1] rdy;

	logic [ACC_W-1:0]  acc_s1, acc_s2, acc_s3, qu_s3, rem_s4;
	logic              neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
	logic              keep_s1, keep_s2, keep_s3, keep_s4, keep_s5, keep_s6, keep_s7, keep_s8;
	logic [PROD_W-1:0] prod_s2, prod_s6;
	logic [QUO_W-1:0]  quo_s3, quo_s4;
	logic [DEG_W-1:0]  degu_s5, degu_s6;
	logic [MINX_W-1:0] minx_s5;
	logic [OUT_W-1:0]  mag_s7, value_s8;

	logic [47:0]       qu_full;
	logic [ACC_W:0]    rem0, rem1;
	logic [55:0]       minx_full;
	logic [DEG_W-1:0]  deg_sum;

	always_comb begin
		rdy[NSTAGE+1] = out_ready;
		for (int k = NSTAGE; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_s[NSTAGE];
	assign value     = value_s8;
	assign keep      = keep_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= in_valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign qu_full   = 48'(prod_s2[RECIP_SHIFT +: QUO_W]) * 48'(UNIT);
	assign rem0      = {1'b0, acc_s3} - {1'b0, qu_s3};
	assign rem1      = rem0 - (ACC_W+1)'(UNIT);
	assign minx_full = 56'(rem_s4) * 56'(SCALE);
	assign deg_sum   = degu_s6 + DEG_W'(prod_s6[PROD_W-1:32]);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			acc_s1  <= req.acc;
			neg_s1  <= req.neg;
			keep_s1 <= req.keep;
		end
		// degrees estimate by reciprocal, at most one short
		if (rdy[2]) begin
			prod_s2 <= PROD_W'(acc_s1) * PROD_W'(RECIP);
			acc_s2  <= acc_s1;
			neg_s2  <= neg_s1;
			keep_s2 <= keep_s1;
		end
		if (rdy[3]) begin
			quo_s3  <= prod_s2[RECIP_SHIFT +: QUO_W];
			qu_s3   <= qu_full[ACC_W-1:0];
			acc_s3  <= acc_s2;
			neg_s3  <= neg_s2;
			keep_s3 <= keep_s2;
		end
		if (rdy[4]) begin
			if (!rem1[ACC_W]) begin
				quo_s4 <= quo_s3 + QUO_W'(1);
				rem_s4 <= rem1[ACC_W-1:0];
			end else begin
				quo_s4 <= quo_s3;
				rem_s4 <= rem0[ACC_W-1:0];
			end
			neg_s4  <= neg_s3;
			keep_s4 <= keep_s3;
		end
		if (rdy[5]) begin
			degu_s5 <= DEG_W'(quo_s4) * DEG_W'(TEN7);
			minx_s5 <= minx_full[MINX_W-1:0];
			neg_s5  <= neg_s4;
			keep_s5 <= keep_s4;
		end
		// minutes / 60 as (x/4)/15
		if (rdy[6]) begin
			prod_s6 <= PROD_W'(minx_s5[MINX_W-1:2]) * PROD_W'(RECIP15);
			degu_s6 <= degu_s5;
			neg_s6  <= neg_s5;
			keep_s6 <= keep_s5;
		end
		if (rdy[7]) begin
			mag_s7  <= (deg_sum > DEG_W'(LIMIT)) ? OUT_W'(LIMIT) : deg_sum[OUT_W-1:0];
			neg_s7  <= neg_s6;
			keep_s7 <= keep_s6;
		end
		if (rdy[8]) begin
			if (!keep_s7) begin
				value_s8 <= '0;
			end else if (neg_s7) begin
				value_s8 <= -mag_s7;
			end else begin
				value_s8 <= mag_s7;
			end
			keep_s8 <= keep_s7;
		end
	end

	a_rem_below_unit: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[4] |-> (64'(rem_s4) < UNIT))
		else $error("remainder not reduced below one degree");

	a_mag_limited: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[7] |-> (mag_s7 <= OUT_W'(LIMIT)))
		else $error("magnitude above limit");

	a_zero_when_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !keep) |-> (value == '0))
		else $error("non-zero value on invalid fix");

endmodule

`default_nettype wire

// ----- hdl/nmea_rmc_position_parser_core.sv -----
// NMEA RMC position parser: byte stream in, one fix result per line out.
//
// s_* carries received characters, one per beat. A line ends at a newline
// (not part of the line) or once LINE_MAX-1 characters are in. Each line end
// gives exactly one beat on m_*: fix_valid plus latitude and longitude in
// 1e-7 degree (zero when the line is not a valid $GPRMC with status A).
//
// Throughput: one character per cycle while s_tready is high, line ends
// included. Per-character work is a single register stage of parse state;
// the degree conversion is an eight-stage pipeline per coordinate (one
// reciprocal multiply with a correction step for the degree split, one
// for minutes/60). The result of a line is registered through all eight
// conversion stages before it reaches m_tdata.
// Stall: each conversion stage holds only while the one after it is full, so
// up to eight results queue before s_tready drops.
// Reset: parse state returns to the start of a line and the pipeline empties.
// Depends on nrmc_pkg and nrmc_deg_conv.
`default_nettype none

module nmea_rmc_position_parser_core #(
	parameter int LINE_MAX        = nrmc_pkg::LINE_MAX_DEF,
	parameter int FRACTION_DIGITS = nrmc_pkg::FRAC_DIGITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata    // [0] fix_valid, [31:1] latitude, [63:32] longitude
);
	import nrmc_pkg::*;

	localparam int          POS_W  = $clog2(LINE_MAX);
	localparam logic [63:0] TEN_FD = pow10(4'(FRACTION_DIGITS));

	logic [POS_W-1:0]      pos_q;
	line_state_t           line_q, fed, src;

	logic                  accept, is_nl, at_limit, line_end, fix_ok;
	logic                  first, digit, skip;
	logic [4:0]            idx;
	logic [3:0]            dval;
	logic [ACC_W-1:0]      acc_v;
	logic                  neg_v;
	logic [1:0]            stage_v;
	logic [FRAC_CNT_W-1:0] frac_v, frac_nxt;
	logic [31:0]           sum_int, sum_frac;

	conv_req_t             lat_req, lon_req;
	logic                  lat_rdy, lon_rdy, lat_ov, lon_ov, lat_keep, lon_keep;
	logic [LAT_W-1:0]      lat_val;
	logic [LON_W-1:0]      lon_val;

	assign is_nl    = (s_tdata == CH_NL);
	assign at_limit = (pos_q == POS_W'(LINE_MAX - 2));
	assign accept   = s_tvalid && s_tready;
	assign line_end = is_nl || at_limit;

	// next line state for one character (newline excluded)
	always_comb begin
		fed      = line_q;
		first    = 1'b0;
		skip     = 1'b0;
		digit    = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
		dval     = s_tdata[3:0];
		idx      = 5'(line_q.field_no - 5'd1);
		acc_v    = '0;
		neg_v    = 1'b0;
		stage_v  = NUM_LEAD;
		frac_v   = '0;
		frac_nxt = '0;
		sum_int  = '0;
		sum_frac = '0;
		if (!line_q.text_end) begin
			if (s_tdata == CH_NUL) begin
				fed.text_end = 1'b1;
				if (pos_q < POS_W'(PREFIX_LEN)) begin
					fed.prefix_ok = 1'b0;
				end
			end else begin
				if (pos_q < POS_W'(PREFIX_LEN) && s_tdata != prefix_char(pos_q[2:0])) begin
					fed.prefix_ok = 1'b0;
				end
				if (s_tdata == CH_COMMA) begin
					fed.in_token = 1'b0;
				end else begin
					if (!line_q.in_token) begin
						first          = 1'b1;
						fed.in_token   = 1'b1;
						fed.num_stage  = NUM_LEAD;
						fed.frac_cnt   = '0;
						if (line_q.field_no < FIELD_SAT) begin
							fed.field_no = line_q.field_no + 5'd1;
						end
					end
					idx = 5'(fed.field_no - 5'd1);

					// number reader, shared by both coordinates
					acc_v   = (idx == FLD_LON) ? fed.lon_acc : fed.lat_acc;
					neg_v   = (idx == FLD_LON) ? fed.lon_neg : fed.lat_neg;
					stage_v = fed.num_stage;
					frac_v  = fed.frac_cnt;
					if (stage_v == NUM_LEAD) begin
						if (s_tdata == CH_TAB || s_tdata == CH_VT || s_tdata == CH_FF ||
						    s_tdata == CH_CR || s_tdata == CH_SPACE) begin
							skip = 1'b1;
						end else if (s_tdata == CH_PLUS) begin
							stage_v = NUM_INT;
							skip    = 1'b1;
						end else if (s_tdata == CH_MINUS) begin
							neg_v   = 1'b1;
							stage_v = NUM_INT;
							skip    = 1'b1;
						end else begin
							stage_v = NUM_INT;
						end
					end
					frac_nxt = frac_v + FRAC_CNT_W'(1);
					sum_int  = (32'(acc_v) << 3) + (32'(acc_v) << 1) +
					           32'(dval) * 32'(TEN_FD);
					sum_frac = 32'(acc_v) + 32'(dval) *
					           32'(pow10(4'(FRACTION_DIGITS) - 4'(frac_nxt)));
					if (!skip) begin
						if (stage_v == NUM_INT) begin
							if (digit) begin
								acc_v = (sum_int > 32'(ACC_MAX)) ? ACC_MAX : sum_int[ACC_W-1:0];
							end else if (s_tdata == CH_DOT) begin
								stage_v = NUM_FRAC;
							end else begin
								stage_v = NUM_STOP;
							end
						end else if (stage_v == NUM_FRAC) begin
							if (digit) begin
								if (frac_v < FRAC_CNT_W'(FRACTION_DIGITS)) begin
									frac_v = frac_nxt;
									acc_v  = (sum_frac > 32'(ACC_MAX)) ? ACC_MAX :
									         sum_frac[ACC_W-1:0];
								end
							end else begin
								stage_v = NUM_STOP;
							end
						end
					end

					unique case (idx)
						FLD_STATUS: fed.status = (first && s_tdata == CH_A) ? ST_A : ST_OTHER;
						FLD_LAT: begin
							fed.lat_acc   = acc_v;
							fed.lat_neg   = neg_v;
							fed.num_stage = stage_v;
							fed.frac_cnt  = frac_v;
						end
						FLD_NS: begin
							if (first) begin
								fed.south = (s_tdata == CH_S);
							end
						end
						FLD_LON: begin
							fed.lon_acc   = acc_v;
							fed.lon_neg   = neg_v;
							fed.num_stage = stage_v;
							fed.frac_cnt  = frac_v;
						end
						FLD_EW: begin
							if (first) begin
								fed.west = (s_tdata == CH_W);
							end
						end
						default: ;
					endcase
				end
			end
		end
	end

	// newline closes on the state as it stands; the length limit after this byte
	assign src    = is_nl ? line_q : fed;
	assign fix_ok = src.prefix_ok && (src.field_no >= MIN_FIELDS) && (src.status == ST_A);

	assign lat_req = '{acc: src.lat_acc, neg: src.lat_neg ^ src.south, keep: fix_ok};
	assign lon_req = '{acc: src.lon_acc, neg: src.lon_neg ^ src.west, keep: fix_ok};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			line_q <= LINE_CLEAR;
		end else if (accept) begin
			if (line_end) begin
				pos_q  <= '0;
				line_q <= LINE_CLEAR;
			end else begin
				pos_q  <= pos_q + POS_W'(1);
				line_q <= fed;
			end
		end
	end

	assign s_tready = lat_rdy && lon_rdy;

	nrmc_deg_conv #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.LIMIT           (LAT_LIMIT),
		.OUT_W           (LAT_W)
	) u_lat (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid && line_end),
		.in_ready  (lat_rdy),
		.req       (lat_req),
		.out_valid (lat_ov),
		.out_ready (m_tready),
		.value     (lat_val),
		.keep      (lat_keep)
	);

	nrmc_deg_conv #(
		.FRACTION_DIGITS (FRACTION_DIGITS),
		.LIMIT           (LON_LIMIT),
		.OUT_W           (LON_W)
	) u_lon (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid && line_end),
		.in_ready  (lon_rdy),
		.req       (lon_req),
		.out_valid (lon_ov),
		.out_ready (m_tready),
		.value     (lon_val),
		.keep      (lon_keep)
	);

	assign m_tvalid = lat_ov && lon_ov;
	assign m_tdata  = {lon_val, lat_val, lat_keep && lon_keep};

	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		(lat_rdy == lon_rdy) && (lat_ov == lon_ov))
		else $error("coordinate pipelines out of step");

	a_newline_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_nl) |=> (pos_q == '0) && (line_q == LINE_CLEAR))
		else $error("line state not cleared after newline");

	a_limit_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && at_limit) |=> (pos_q == '0))
		else $error("line length limit not honoured");

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for nmea_rmc_position_parser_core: byte stream in, fix results out.
// Parses each accepted byte in a local line parser and compares every fix beat against it.
// Depends on nrmc_pkg and the parser RTL.
`timescale 1ns / 100ps

module tb_top;
	import nrmc_pkg::*;

	localparam int LINE_MAX    = LINE_MAX_DEF;
	localparam int FRAC_DIG    = FRAC_DIGITS_DEF;
	localparam int ITEMS       = 1750;
	localparam int HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [47:0] RMC_HDR = "$GPRMC";
	localparam logic [7:0]  CH_N    = 8'h4e;
	localparam logic [7:0]  CH_E    = 8'h45;

	typedef struct packed {
		logic               valid;
		logic signed [30:0] lat;
		logic signed [31:0] lon;
	} fix_t;

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;     // [7:0] rx_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;           // [0] fix_valid, [31:1] latitude, [63:32] longitude

	logic [7:0] tx_q[$];
	logic [7:0] line_buf[$];
	fix_t       fix_q[$];
	fix_t       fix_head;
	int         pushed, sent_n, got_n, err_n, hold_cnt, cyc;
	logic       hold_req  = 1'b0;
	logic       hold_done = 1'b0;

	// line parser state
	int                    ln_len;
	int                    frac_n;
	logic [4:0]            tok_cnt;
	logic                  in_tok, pfx_ok, text_end;
	logic [1:0]            stat, num_st;
	logic [ACC_W-1:0]      lat_acc, lon_acc;
	logic                  lat_minus, lon_minus, south, west;

	nmea_rmc_position_parser_core #(
		.LINE_MAX        (LINE_MAX),
		.FRACTION_DIGITS (FRAC_DIG)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint unsigned p10(input int n);
		longint unsigned p;
		p = 1;
		repeat (n) p = p * 10;
		return p;
	endfunction

	function automatic logic [ACC_W-1:0] acc_add(input longint unsigned a, input longint unsigned b);
		longint unsigned s;
		s = a + b;
		return (s > ACC_MAX) ? ACC_MAX : s[ACC_W-1:0];
	endfunction

	function automatic longint unsigned coord_deg(input logic [ACC_W-1:0] acc, input logic minus,
			input logic flip, input longint unsigned cap);
		longint unsigned scale, whole, mins, mag;
		scale = 100 * p10(FRAC_DIG);
		whole = acc / scale;
		mins  = acc % scale;
		mag   = whole * p10(7) + (mins * p10(7)) / (60 * p10(FRAC_DIG));
		if (mag > cap)
			mag = cap;
		if (minus != flip)
			mag = -mag;
		return mag;
	endfunction

	task automatic line_reset();
		ln_len    = 0;
		frac_n    = 0;
		tok_cnt   = '0;
		in_tok    = 1'b0;
		pfx_ok    = 1'b1;
		text_end  = 1'b0;
		stat      = ST_NONE;
		num_st    = NUM_LEAD;
		lat_acc   = '0;
		lon_acc   = '0;
		lat_minus = 1'b0;
		lon_minus = 1'b0;
		south     = 1'b0;
		west      = 1'b0;
	endtask

	// ddmm.mmmm reader: blanks, one sign, digits, then fraction digits truncated
	task automatic feed_coord(input logic [7:0] c, inout logic [ACC_W-1:0] acc, inout logic minus);
		logic            is_dig, is_blank, skip;
		longint unsigned d;
		is_dig   = (c >= CH_ZERO && c <= CH_NINE);
		is_blank = (c == CH_TAB || c == CH_VT || c == CH_FF || c == CH_CR || c == CH_SPACE);
		d        = 64'(c - CH_ZERO);
		skip     = 1'b0;
		if (num_st == NUM_LEAD) begin
			skip = is_blank || c == CH_PLUS || c == CH_MINUS;
			if (c == CH_MINUS)
				minus = 1'b1;
			if (!is_blank)
				num_st = NUM_INT;
		end
		if (!skip) begin
			if (num_st == NUM_INT) begin
				if (is_dig)
					acc = acc_add(64'(acc) * 10, d * p10(FRAC_DIG));
				else if (c == CH_DOT)
					num_st = NUM_FRAC;
				else
					num_st = NUM_STOP;
			end else if (num_st == NUM_FRAC) begin
				if (!is_dig) begin
					num_st = NUM_STOP;
				end else if (frac_n < FRAC_DIG) begin
					frac_n++;
					acc = acc_add(64'(acc), d * p10(FRAC_DIG - frac_n));
				end
			end
		end
	endtask

	task automatic feed_text(input logic [7:0] c);
		logic lead;
		lead = 1'b0;
		if (c == CH_NUL) begin
			text_end = 1'b1;
			if (ln_len < PREFIX_LEN)
				pfx_ok = 1'b0;
		end else begin
			if (ln_len < PREFIX_LEN && c != RMC_HDR[47 - 8*ln_len -: 8])
				pfx_ok = 1'b0;
			if (c == CH_COMMA) begin
				in_tok = 1'b0;
			end else begin
				if (!in_tok) begin
					in_tok = 1'b1;
					lead   = 1'b1;
					if (tok_cnt < FIELD_SAT)
						tok_cnt++;
					num_st = NUM_LEAD;
					frac_n = 0;
				end
				case (tok_cnt - 5'd1)
					FLD_STATUS: stat = (lead && c == CH_A) ? ST_A : ST_OTHER;
					FLD_LAT:    feed_coord(c, lat_acc, lat_minus);
					FLD_NS:     if (lead) south = (c == CH_S);
					FLD_LON:    feed_coord(c, lon_acc, lon_minus);
					FLD_EW:     if (lead) west = (c == CH_W);
					default:    ;
				endcase
			end
		end
	endtask

	task automatic close_line();
		fix_t            f;
		longint unsigned la, lo;
		f = '0;
		if (pfx_ok && tok_cnt >= MIN_FIELDS && stat == ST_A) begin
			la      = coord_deg(lat_acc, lat_minus, south, LAT_LIMIT);
			lo      = coord_deg(lon_acc, lon_minus, west, LON_LIMIT);
			f.valid = 1'b1;
			f.lat   = la[30:0];
			f.lon   = lo[31:0];
		end
		fix_q.push_back(f);
		line_reset();
	endtask

	task automatic parse_char(input logic [7:0] c);
		if (c == CH_NL) begin
			close_line();
		end else begin
			if (!text_end)
				feed_text(c);
			ln_len++;
			if (ln_len >= LINE_MAX - 1)
				close_line();
		end
	endtask

	// ---- stimulus building ----
	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic add_digits(input int n);
		repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic add_sep();
		line_buf.push_back(CH_COMMA);
		if ($urandom_range(99) < 12)
			line_buf.push_back(CH_COMMA);
	endtask

	task automatic add_blank();
		case ($urandom_range(4))
			0:       line_buf.push_back(CH_TAB);
			1:       line_buf.push_back(CH_VT);
			2:       line_buf.push_back(CH_FF);
			3:       line_buf.push_back(CH_CR);
			default: line_buf.push_back(CH_SPACE);
		endcase
	endtask

	task automatic add_coord();
		int r;
		if ($urandom_range(99) < 15)
			repeat ($urandom_range(1, 2)) add_blank();
		r = $urandom_range(99);
		if (r < 8)
			line_buf.push_back(CH_MINUS);
		else if (r < 16)
			line_buf.push_back(CH_PLUS);
		r = $urandom_range(99);
		if (r < 85)
			add_digits($urandom_range(4, 5));
		else if (r < 95)
			add_digits($urandom_range(0, 3));
		else
			add_digits($urandom_range(8, 11));   // drives the accumulator into saturation
		if ($urandom_range(99) < 80) begin
			line_buf.push_back(CH_DOT);
			add_digits($urandom_range(0, 7));
		end
		if ($urandom_range(99) < 5)
			line_buf.push_back(8'($urandom_range(33, 126)));
	endtask

	task automatic add_dir(input logic [7:0] a, input logic [7:0] b);
		int r;
		r = $urandom_range(99);
		if (r < 45)
			line_buf.push_back(a);
		else if (r < 90)
			line_buf.push_back(b);
		else if (r < 95)
			line_buf.push_back(8'($urandom_range(33, 126)));
	endtask

	// hand the built line to the driver, optionally damaged
	task automatic end_line(input logic mangle);
		int cut;
		if (mangle) begin
			if ($urandom_range(99) < 8) begin
				cut = $urandom_range(line_buf.size());
				while (line_buf.size() > cut)
					void'(line_buf.pop_back());
			end
			if ($urandom_range(99) < 5 && line_buf.size() != 0)
				line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
			if ($urandom_range(99) < 3)
				line_buf.insert($urandom_range(line_buf.size()), CH_NUL);
			if ($urandom_range(99) < 30)
				line_buf.push_back(CH_CR);
		end
		line_buf.push_back(CH_NL);
		foreach (line_buf[i]) begin
			tx_q.push_back(line_buf[i]);
			pushed++;
		end
		line_buf.delete();
	endtask

	task automatic put_line(input string s);
		add_str(s);
		end_line(1'b0);
	endtask

	task automatic rand_sentence();
		int r;
		add_str("$GPRMC");
		if ($urandom_range(99) < 8)
			line_buf[$urandom_range(5)] = 8'($urandom_range(32, 126));
		add_sep();
		add_digits($urandom_range(0, 6));
		add_sep();
		r = $urandom_range(99);
		if (r < 80)
			add_str("A");
		else if (r < 90)
			add_str("V");
		else if (r < 95)
			add_str("AV");
		add_sep();
		add_coord();
		add_sep();
		add_dir(CH_N, CH_S);
		add_sep();
		add_coord();
		add_sep();
		add_dir(CH_E, CH_W);
		repeat ($urandom_range(0, 5)) begin
			add_sep();
			add_digits($urandom_range(0, 5));
		end
		if ($urandom_range(1)) begin
			add_str("*");
			add_digits(2);
		end
		end_line(1'b1);
	endtask

	task automatic noise_line();
		repeat ($urandom_range(1, 40)) line_buf.push_back(8'($urandom_range(255)));
		end_line(1'b0);
	endtask

	task automatic drain();
		while (tx_q.size() != 0 || s_tvalid || fix_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic take_gap();
		return !(sent_n >= 900 && sent_n < 1300) && ($urandom_range(99) < 11);
	endfunction

	// ---- byte driver ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata);
				sent_n++;
			end
			if (!s_tvalid || s_tready) begin
				if (tx_q.size() != 0 && !take_gap()) begin
					s_tvalid <= 1'b1;
					s_tdata  <= tx_q.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---- fix monitor and receiver ----
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_n++;
				if (fix_q.size() == 0) begin
					err_n++;
					if (err_n <= 10)
						$display("fix beat with nothing expected: %h", m_tdata);
				end else begin
					fix_head = fix_q.pop_front();
					if (m_tdata[0] !== fix_head.valid || m_tdata[31:1] !== fix_head.lat ||
							m_tdata[63:32] !== fix_head.lon) begin
						err_n++;
						if (err_n <= 10)
							$display("fix mismatch: valid exp %0d act %0d, lat exp %0d act %0d, lon exp %0d act %0d",
								fix_head.valid, m_tdata[0], fix_head.lat, $signed(m_tdata[31:1]),
								fix_head.lon, $signed(m_tdata[63:32]));
					end
				end
			end
			if (hold_cnt != 0) begin
				hold_cnt--;
				m_tready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_cnt  = HOLD_CYCLES;
				hold_done = 1'b1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (got_n >= 20 && got_n < 32) || ($urandom_range(99) >= 11);
			end
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		line_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		put_line("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A");
		put_line("$GPRMC,000000,A,3351.5402,S,15112.8103,W,0.0,0.0,010100,,*00");
		put_line("$GPRMC,1,A, \t-0130.55559,S,+17959.99999,E");
		put_line("$GPRMC,1,A,99999999999,N,-99999999999.9,W");
		put_line("$GPRMC,1,V,4807.038,N,01131.000,E");
		put_line("$GPRMC,1,AA,1,N,2,E");
		put_line("$GPRMC,,1,,A,,12.5,,N,,1,,E");
		put_line("$GPRMC,1,A,1,N");
		put_line("");
		put_line("$GPRMX,1,A,1,N,1,E");
		// zero byte inside the header fails the prefix
		add_str("$GPR");
		line_buf.push_back(CH_NUL);
		put_line("MC,1,A,1,N,1,E");
		// zero byte after the fields hides the rest of the line
		add_str("$GPRMC,1,A,4807.038,N,01131.000,E");
		line_buf.push_back(CH_NUL);
		put_line("junk,S,W");
		add_str("$GPRMC,1,A,x12,N,.5.5,E,");
		line_buf.push_back(8'hff);
		line_buf.push_back(8'h80);
		put_line("");
		add_str("$GPRMC,1,A,1,N,1,E");
		repeat (30) add_str(",x");
		put_line("");
		// overlong line is cut, the tail forms a line of its own
		add_str("$GPRMC,1,A,1,N,1,E,");
		repeat (120) add_str("9");
		put_line("");
		drain();

		// receiver holds off while short lines keep coming, so the input stalls
		@(posedge clk);
		hold_req <= 1'b1;
		repeat (6) begin
			repeat (4) put_line("");
			put_line("$GPRMC,1,A,4500.0,S,9000.0,W");
		end
		drain();

		while (pushed < ITEMS) begin
			if ($urandom_range(99) < 6)
				noise_line();
			else
				rand_sentence();
		end
		drain();
		repeat (20) @(posedge clk);
		if (err_n == 0 && fix_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
